// File: rtl/tlge_pkg.sv
package tlge_pkg;

  // Grid geometry
  localparam int GRID_COLS = 128;
  localparam int GRID_ROWS = 64;

  // Row address and column index widths follow from the geometry
  localparam int ROW_AW = $clog2(GRID_ROWS);
  localparam int COL_AW = $clog2(GRID_COLS);

  // Request and result field widths
  localparam int OP_W  = 2;
  localparam int COL_W = 7;
  localparam int ROW_W = 6;

  // Life rule constants
  localparam int BIRTH_COUNT = 3;
  localparam int KEEP_COUNT  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

endpackage

// File: rtl/tlge_ram.sv
module tlge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/tlge_row_rule.sv
module tlge_row_rule (
  input  logic [tlge_pkg::GRID_COLS-1:0] above_row,
  input  logic [tlge_pkg::GRID_COLS-1:0] mid_row,
  input  logic [tlge_pkg::GRID_COLS-1:0] below_row,
  output logic [tlge_pkg::GRID_COLS-1:0] next_row
);

  import tlge_pkg::*;

  // One counter and rule per column; columns wrap at both ends.
  for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
    localparam int L = (c == 0) ? GRID_COLS - 1 : c - 1;
    localparam int R = (c == GRID_COLS - 1) ? 0 : c + 1;

    logic [3:0] cnt;

    assign cnt = 4'(above_row[L]) + 4'(above_row[c]) + 4'(above_row[R])
               + 4'(mid_row[L])                      + 4'(mid_row[R])
               + 4'(below_row[L]) + 4'(below_row[c]) + 4'(below_row[R]);

    assign next_row[c] = (cnt == 4'(BIRTH_COUNT))
                       | ((cnt == 4'(KEEP_COUNT)) & mid_row[c]);
  end

endmodule

// File: rtl/toroidal_life_grid_engine_top.sv
// Flow: an on-grid write or read runs S_CELL_RD, S_CELL_WB, S_DONE; an unused op code
//   or off-grid cell goes to S_DONE directly; a step runs S_PRE, S_SWEEP, S_DONE.
// Throughput: one request at a time; the next request is taken from the cycle
//   the result goes valid. The row memory port and the single row rule unit
//   (one full row per cycle) set the step time; a stalled result holds the engine.
// Reset: synchronous, active high; all cells read dead after reset through
//   per-row valid flags, so no clearing pass is needed.
module toroidal_life_grid_engine_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [tlge_pkg::OP_W-1:0]  op,
  input  logic [tlge_pkg::COL_W-1:0] col,
  input  logic [tlge_pkg::ROW_W-1:0] row,
  input  logic                       value,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic                       cell_value,
  output logic [tlge_pkg::OP_W-1:0]  done_op
);

  import tlge_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CELL_RD = 6'b000010,
    S_CELL_WB = 6'b000100,
    S_PRE     = 6'b001000,
    S_SWEEP   = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(GRID_ROWS - 1);

  state_t state;

  // Latched request
  logic [OP_W-1:0]   op_q;
  logic [ROW_AW-1:0] row_q;
  logic [COL_AW-1:0] col_q;
  logic              value_q;
  logic              cell_q;

  // Sweep state: three-row window plus the old top row for the wrap at the end
  logic [1:0]           pre_cnt;
  logic [ROW_AW-1:0]    sweep_row;
  logic [GRID_COLS-1:0] prev_row;
  logic [GRID_COLS-1:0] cur_row;
  logic [GRID_COLS-1:0] nxt_row;
  logic [GRID_COLS-1:0] first_row;
  logic [GRID_COLS-1:0] new_row;

  // Row memory controls
  logic                 wr_en;
  logic [ROW_AW-1:0]    wr_addr;
  logic [GRID_COLS-1:0] wr_data;
  logic [ROW_AW-1:0]    rd_addr;
  logic [GRID_COLS-1:0] rd_data;
  logic [GRID_COLS-1:0] rd_row;
  logic [GRID_COLS-1:0] cell_row;

  // A row never written since reset reads as all dead
  logic [GRID_ROWS-1:0] row_valid;
  logic                 rd_valid_q;

  logic accept;
  logic coord_ok;
  logic out_free;
  logic sweep_use_rd;
  logic sweep_rd_ok;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);
  assign coord_ok   = (32'(col) < GRID_COLS) && (32'(row) < GRID_ROWS);
  assign out_free   = !result_valid || !result_stall;

  assign rd_row = rd_valid_q ? rd_data : '0;

  // Row r+2 comes from memory while it exists; past the bottom, wrap to the old top row.
  assign sweep_use_rd = (32'(sweep_row) + 2) < GRID_ROWS;
  // Prefetch row r+3 for the next sweep cycle when it exists.
  assign sweep_rd_ok  = (32'(sweep_row) + 3) < GRID_ROWS;

  // Read-modify-write data for a single-cell write
  always_comb begin
    cell_row        = rd_row;
    cell_row[col_q] = value_q;
  end

  tlge_ram #(
    .WIDTH (GRID_COLS),
    .DEPTH (GRID_ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tlge_row_rule u_rule (
    .above_row (prev_row),
    .mid_row   (cur_row),
    .below_row (nxt_row),
    .next_row  (new_row)
  );

  // Memory port steering
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = row_q;
    wr_data = cell_row;
    case (state)
      S_CELL_RD: begin
        rd_addr = row_q;
      end
      S_CELL_WB: begin
        wr_en = (op_q == OP_WRITE);
      end
      S_PRE: begin
        case (pre_cnt)
          2'd0:    rd_addr = '0;
          2'd1:    rd_addr = ROW_AW'(1);
          2'd2:    rd_addr = LAST_ROW;
          default: rd_addr = ROW_AW'(2);
        endcase
      end
      S_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_row;
        wr_data = new_row;
        rd_addr = sweep_rd_ok ? ROW_AW'(32'(sweep_row) + 3) : '0;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Row valid flags; sample the flag alongside the registered read
  always_ff @(posedge clk) begin
    rd_valid_q <= row_valid[rd_addr];
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pre_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            pre_cnt <= '0;
            if (op == OP_STEP) begin
              state <= S_PRE;
            end else if ((op == OP_WRITE || op == OP_READ) && coord_ok) begin
              state <= S_CELL_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_CELL_RD: state <= S_CELL_WB;
        S_CELL_WB: state <= S_DONE;
        S_PRE: begin
          pre_cnt <= pre_cnt + 2'd1;
          if (pre_cnt == 2'd3) begin
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (sweep_row == LAST_ROW) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request payload and sweep datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op;
      row_q   <= ROW_AW'(row);
      col_q   <= COL_AW'(col);
      value_q <= value;
      cell_q  <= 1'b0;
    end
    if (state == S_CELL_WB && op_q == OP_READ) begin
      cell_q <= rd_row[col_q];
    end
    if (state == S_PRE) begin
      case (pre_cnt)
        2'd1: begin
          cur_row   <= rd_row;
          first_row <= rd_row;
        end
        2'd2: nxt_row <= rd_row;
        2'd3: begin
          prev_row  <= rd_row;
          sweep_row <= '0;
        end
        default: ;
      endcase
    end
    if (state == S_SWEEP) begin
      // Advance the window one row down
      prev_row  <= cur_row;
      cur_row   <= nxt_row;
      nxt_row   <= sweep_use_rd ? rd_row : first_row;
      sweep_row <= sweep_row + ROW_AW'(1);
    end
  end

  // Output register: hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      cell_value <= cell_q;
      done_op    <= op_q;
    end
  end

endmodule

// File: rtl/tlge_checker.sv
module tlge_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_stall,
  input logic [tlge_pkg::OP_W-1:0]  op,
  input logic [tlge_pkg::COL_W-1:0] col,
  input logic [tlge_pkg::ROW_W-1:0] row,
  input logic                       value,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic                       cell_value,
  input logic [tlge_pkg::OP_W-1:0]  done_op
);

  import tlge_pkg::*;

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(cell_value) && $stable(done_op))
    else $error("stalled result changed");

  // A stalled request holds its payload
  a_request_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(op) && $stable(col)
      && $stable(row) && $stable(value))
    else $error("stalled request changed");

  // Only reads return a live cell
  a_cell_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (done_op != OP_READ) |-> !cell_value)
    else $error("nonzero cell value on a non-read result");

  // One request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("accepted a request while busy");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind toroidal_life_grid_engine_top tlge_checker u_tlge_checker (.*);

// File: tb/life_grid_tracker_pkg.sv
`timescale 1ns / 1ps

package life_grid_tracker_pkg;
  import tlge_pkg::*;

  typedef struct {
    bit  live;
    op_t op;
  } cell_result_t;

  class life_grid_tracker;
    bit [GRID_COLS-1:0] cells [GRID_ROWS];
    cell_result_t       pending [$];
    int                 mismatches;
    int                 checked;
    int                 op_seen [4];

    function new();
      foreach (cells[r]) cells[r] = '0;
      mismatches = 0;
      checked    = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    // Build the next generation from a frozen copy of the current one.
    function void advance_generation();
      bit [GRID_COLS-1:0] snap [GRID_ROWS];
      bit [GRID_COLS-1:0] up, mid, dn;
      int cl, cr, n;
      snap = cells;
      for (int r = 0; r < GRID_ROWS; r++) begin
        up  = snap[(r + GRID_ROWS - 1) % GRID_ROWS];
        mid = snap[r];
        dn  = snap[(r + 1) % GRID_ROWS];
        for (int c = 0; c < GRID_COLS; c++) begin
          cl = (c + GRID_COLS - 1) % GRID_COLS;
          cr = (c + 1) % GRID_COLS;
          n  = up[cl] + up[c] + up[cr] + mid[cl] + mid[cr] + dn[cl] + dn[c] + dn[cr];
          if (n == BIRTH_COUNT) begin
            cells[r][c] = 1'b1;
          end else if (n != KEEP_COUNT) begin
            cells[r][c] = 1'b0;
          end
        end
      end
    endfunction

    function void apply_request(op_t o, bit [COL_W-1:0] c, bit [ROW_W-1:0] r, bit v);
      cell_result_t want;
      bit on_grid;
      on_grid   = (c < GRID_COLS) && (r < GRID_ROWS);
      want.live = 1'b0;
      want.op   = o;
      op_seen[int'(o)]++;
      case (o)
        OP_WRITE: begin
          if (on_grid) cells[r][c] = v;
        end
        OP_READ: begin
          if (on_grid) want.live = cells[r][c];
        end
        OP_STEP: begin
          advance_generation();
        end
        default: ;
      endcase
      pending.push_back(want);
    endfunction

    function void check_result(logic cv, logic [OP_W-1:0] dop);
      cell_result_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result %0d with no request outstanding: %s",
                   $time, checked,
                   $sformatf("cell_value=%0b done_op=%0d", cv, dop));
        return;
      end
      want = pending.pop_front();
      if (cv !== want.live || dop !== want.op) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result %0d mismatch: expected cell_value=%0b done_op=%0d, %s",
                   $time, checked, want.live, want.op,
                   $sformatf("got cell_value=%0b done_op=%0d", cv, dop));
      end
    endfunction
  endclass

endpackage

// File: tb/tb_toroidal_life_grid_engine_top.sv
`timescale 1ns / 1ps

module tb_toroidal_life_grid_engine_top;
  import tlge_pkg::*;
  import life_grid_tracker_pkg::*;

  logic             clk = 1'b0;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  logic [OP_W-1:0]  op;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             value;
  logic             result_valid;
  logic             result_stall;
  logic             cell_value;
  logic [OP_W-1:0]  done_op;

  life_grid_tracker tracker;

  // Requests that do real work (unused op code not counted)
  int requests_sent = 0;
  // Calm phases: no idle cycles on the request side / no stalls on the result side
  bit send_calm  = 1'b0;
  bit drain_calm = 1'b0;
  int stall_left = 0;

  toroidal_life_grid_engine_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .col          (col),
    .row          (row),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cell_value   (cell_value),
    .done_op      (done_op)
  );

  always #6 clk = ~clk;

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one request and hold it until the block takes it. Valid stays
  // high across back-to-back requests, so it is only lowered ahead of a gap.
  task automatic send_request(input op_t o, input int c, input int r, input bit v);
    int gap;
    gap = send_calm ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op         <= o;
    col        <= c[COL_W-1:0];
    row        <= r[ROW_W-1:0];
    value      <= v;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    tracker.apply_request(o, c[COL_W-1:0], r[ROW_W-1:0], v);
    if (o != OP_NONE) requests_sent++;
  endtask

  // Seed a small random patch (it may straddle either wrap seam), then run
  // a few generations and probe cells in and around the patch after each.
  task automatic run_soup_episode();
    int c0, r0, w, h, dens, gens, probes, dx, dy;
    c0   = $urandom_range(0, GRID_COLS - 1);
    r0   = $urandom_range(0, GRID_ROWS - 1);
    w    = $urandom_range(3, 8);
    h    = $urandom_range(3, 8);
    dens = $urandom_range(25, 60);
    for (dy = 0; dy < h; dy++) begin
      for (dx = 0; dx < w; dx++) begin
        send_request(OP_WRITE, (c0 + dx) % GRID_COLS, (r0 + dy) % GRID_ROWS,
                     $urandom_range(0, 99) < dens);
      end
    end
    gens = $urandom_range(1, 4);
    repeat (gens) begin
      // Col, row and value are don't-care on a step; randomize them anyway.
      send_request(OP_STEP, $urandom, $urandom, 1'($urandom));
      probes = $urandom_range(3, 8);
      repeat (probes) begin
        send_request(OP_READ,
                     (c0 + GRID_COLS - 2 + $urandom_range(0, w + 3)) % GRID_COLS,
                     (r0 + GRID_ROWS - 2 + $urandom_range(0, h + 3)) % GRID_ROWS,
                     1'($urandom));
      end
      if ($urandom_range(0, 9) == 0) send_request(OP_NONE, $urandom, $urandom, 1'($urandom));
    end
  endtask

  // Fully random requests, unused op code included.
  task automatic run_noise_episode();
    repeat ($urandom_range(5, 20))
      send_request(op_t'($urandom_range(0, 3)), $urandom, $urandom, 1'($urandom));
  endtask

  // Scattered single-cell writes and reads with the odd step thrown in.
  task automatic run_scatter_episode();
    int roll;
    repeat ($urandom_range(4, 12)) begin
      roll = $urandom_range(0, 9);
      if (roll < 5)
        send_request(OP_WRITE, $urandom, $urandom, 1'($urandom));
      else if (roll < 9)
        send_request(OP_READ, $urandom, $urandom, 1'($urandom));
      else
        send_request(OP_STEP, $urandom, $urandom, 1'($urandom));
    end
  endtask

  // Result side: check on every accepted result, then decide the stall for
  // the next cycle. Stalls come in bursts, mostly short, some long, and a
  // calm phase now and then drops stalling altogether.
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall)
        tracker.check_result(cell_value, done_op);
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
        if (!drain_calm && $urandom_range(0, 99) < 20)
          stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                     : $urandom_range(8, 40);
      end
      if ($urandom_range(0, 399) == 0) drain_calm = ~drain_calm;
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb_toroidal_life_grid_engine_top failed");
    $finish;
  end

  initial begin
    int random_base, kind, failures;
    tracker    = new();
    rst        <= 1'b1;
    item_valid <= 1'b0;
    op         <= OP_WRITE;
    col        <= '0;
    row        <= '0;
    value      <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // Fresh grid reads dead.
    send_request(OP_READ, 0, 0, 1'b0);
    send_request(OP_READ, GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
    // Four corners form a 2x2 block across both wrap seams: stable.
    send_request(OP_WRITE, 0, 0, 1'b1);
    send_request(OP_WRITE, GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
    send_request(OP_WRITE, GRID_COLS - 1, 0, 1'b1);
    send_request(OP_WRITE, 0, GRID_ROWS - 1, 1'b1);
    send_request(OP_READ, GRID_COLS - 1, GRID_ROWS - 1, 1'b0);
    // Write a dead cell over a dead cell.
    send_request(OP_WRITE, 64, 32, 1'b0);
    // Horizontal blinker straddling the column seam on row 10.
    send_request(OP_WRITE, GRID_COLS - 1, 10, 1'b1);
    send_request(OP_WRITE, 0, 10, 1'b1);
    send_request(OP_WRITE, 1, 10, 1'b1);
    // Unused op code changes nothing.
    send_request(OP_NONE, GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
    // Step with nonzero don't-care fields; blinker turns vertical.
    send_request(OP_STEP, 85, 42, 1'b1);
    send_request(OP_READ, 0, 9, 1'b1);
    send_request(OP_READ, 0, 11, 1'b0);
    send_request(OP_READ, GRID_COLS - 1, 10, 1'b1);
    send_request(OP_READ, 0, 0, 1'b0);
    send_request(OP_STEP, 0, 0, 1'b0);
    send_request(OP_READ, 1, 10, 1'b0);
    // Kill one corner; the remaining three each see two neighbors and the
    // killed one is reborn with three.
    send_request(OP_WRITE, GRID_COLS - 1, GRID_ROWS - 1, 1'b0);
    send_request(OP_READ, GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
    send_request(OP_STEP, GRID_COLS - 1, GRID_ROWS - 1, 1'b0);
    send_request(OP_READ, GRID_COLS - 1, GRID_ROWS - 1, 1'b0);
    send_request(OP_NONE, 0, 0, 1'b0);

    // Random part, mostly seeded patches that evolve over a few generations.
    random_base = requests_sent;
    while (requests_sent - random_base < 1300) begin
      send_calm = ($urandom_range(0, 5) == 0);
      kind      = $urandom_range(0, 9);
      if (kind < 7)
        run_soup_episode();
      else if (kind < 8)
        run_noise_episode();
      else
        run_scatter_episode();
    end

    // Drop valid, drain outstanding results, then idle past one step latency
    // to catch any stray result.
    item_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (GRID_ROWS + 16) @(posedge clk);

    failures = tracker.mismatches + tracker.pending.size();
    $display("Sent %0d writes, %0d reads, %0d steps and %0d unused-op requests;",
             tracker.op_seen[OP_WRITE], tracker.op_seen[OP_READ],
             tracker.op_seen[OP_STEP], tracker.op_seen[OP_NONE]);
    $display("checked %0d results, %0d mismatches.", tracker.checked, tracker.mismatches);
    if (failures == 0) begin
      $display("tb_toroidal_life_grid_engine_top passed");
    end else begin
      $display("tb_toroidal_life_grid_engine_top failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tlge_pkg.sv
rtl/tlge_ram.sv
rtl/tlge_row_rule.sv
rtl/toroidal_life_grid_engine_top.sv
rtl/tlge_checker.sv
tb/life_grid_tracker_pkg.sv
tb/tb_toroidal_life_grid_engine_top.sv
